/* src/bfde_pkg.sv */
// ============================================================================
// bfde_pkg: shared types and constants for the frame buffer draw engine
// Command codes, sequencer states and default frame limits.
// ============================================================================
package bfde_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0,
        CMD_PUT   = 3'd1,
        CMD_GET   = 3'd2,
        CMD_LINE  = 3'd3,
        CMD_FILL  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECT,
        ST_LINE,
        ST_RWAIT,
        ST_RDATA,
        ST_OUT
    } t_state;

endpackage

/* src/bfde_ram.sv */
// ============================================================================
// bfde_ram: generic single port RAM
// One write or one read per cycle, registered read data.
// ============================================================================
module bfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* src/byte_frame_buffer_draw_engine_core.sv */
// ============================================================================
// byte_frame_buffer_draw_engine_core: 8-bit frame store with draw engine
// Clear, put, get, Bresenham line and clipped rectangle fill.
// ============================================================================
//  channel | signals                          | dir | notes
//  cmd     | i_cmd_valid/o_cmd_ready + fields | in  | one drawing request
//  pix     | o_pix_valid/i_pix_ready, value   | out | get pixel result only
//  cfg     | i_cfg_valid/o_cfg_ready, idx,data| in  | frame width/height
//
//  Put writes in its accept cycle; get reads through ST_RWAIT and ST_RDATA,
//  line and fill/clear step through ST_LINE and ST_RECT. The single RAM port
//  writes one pixel per cycle. Not ready while a request runs or a result waits.
//  Reset is synchronous active low; the store is not cleared by reset.
//  A stalled result holds in the output register until taken.
module byte_frame_buffer_draw_engine_core #(
    parameter int MAX_WIDTH  = bfde_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bfde_pkg::DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  logic [2:0]  i_command,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_end_x,
    input  logic signed [15:0] i_end_y,
    input  logic signed [15:0] i_rect_width,
    input  logic signed [15:0] i_rect_height,
    input  logic [7:0]  i_color,
    output logic        o_pix_valid,
    input  logic        i_pix_ready,
    output logic [7:0]  o_pixel_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import bfde_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // 18-bit signed coords hold 16-bit inputs and sums; 19 bits for line error
    localparam int CW = 18;

    t_state r_state, n_state;
    logic [8:0] r_fw, r_fh;
    logic signed [CW-1:0] r_x, n_x, r_y, n_y, r_x0, n_x0, r_x1, n_x1, r_y1, n_y1;
    logic signed [CW-1:0] r_dx, n_dx, r_dy, n_dy, r_sx, n_sx, r_sy, n_sy;
    logic signed [CW:0]   r_err, n_err;
    logic [7:0] r_color, n_color, r_pix, n_pix;
    logic r_pv, n_pv;

    // effective frame size, clamped to the built maximum
    logic signed [CW-1:0] w_eff, h_eff;
    always_comb begin
        w_eff = (32'(r_fw) > MAX_WIDTH)  ? CW'(MAX_WIDTH)  : CW'(r_fw);
        h_eff = (32'(r_fh) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(r_fh);
    end

    // RAM port
    logic we;
    logic [AW-1:0] addr;
    logic [7:0] wdata;
    logic [7:0] rdata;
    logic [31:0] lin;
    logic in_frame;

    bfde_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 9'd256;
            r_fh <= 9'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == 1'(REG_FRAME_WIDTH)) r_fw <= i_cfg_data;
            else r_fh <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    logic signed [CW-1:0] cx, cy;
    logic signed [CW:0] e2;
    logic signed [CW-1:0] ax, ay, bx, by, rx1, ry1;

    always_comb begin
        n_state = r_state; n_x = r_x; n_y = r_y; n_x0 = r_x0; n_x1 = r_x1;
        n_y1 = r_y1; n_dx = r_dx; n_dy = r_dy; n_sx = r_sx; n_sy = r_sy;
        n_err = r_err; n_color = r_color; n_pix = r_pix; n_pv = r_pv;
        we = 1'b0;
        cx = r_x; cy = r_y;
        e2 = r_err <<< 1;
        ax = CW'(i_start_x); ay = CW'(i_start_y);
        bx = CW'(i_end_x);   by = CW'(i_end_y);
        rx1 = ax + CW'(i_rect_width);
        ry1 = ay + CW'(i_rect_height);
        o_cmd_ready = (r_state == ST_IDLE) && !r_pv;
        // put pixel writes in its accept cycle, before r_color is loaded
        wdata = (r_state == ST_IDLE) ? i_color : r_color;
        if (r_state == ST_IDLE) begin
            cx = ax; cy = ay;
        end
        in_frame = (cx >= 0) && (cy >= 0) && (cx < w_eff) && (cy < h_eff);
        lin = 32'(cy[15:0]) * 32'(w_eff[15:0]) + 32'(cx[15:0]);
        addr = (lin < 32'(DEPTH)) ? AW'(lin) : '0;

        if (r_pv && i_pix_ready) n_pv = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    n_color = i_color;
                    case (i_command)
                        CMD_CLEAR: begin
                            n_x0 = '0; n_x = '0; n_y = '0;
                            n_x1 = w_eff; n_y1 = h_eff;
                            if (w_eff != 0 && h_eff != 0) n_state = ST_RECT;
                        end
                        CMD_PUT: begin
                            we = in_frame;
                        end
                        CMD_GET: begin
                            // hold the read address until the data is registered
                            n_x = ax; n_y = ay;
                            n_state = ST_RWAIT;
                            n_pix = in_frame ? 8'd1 : 8'd0;
                        end
                        CMD_LINE: begin
                            n_x = ax; n_y = ay; n_x1 = bx; n_y1 = by;
                            n_dx = (bx > ax) ? bx - ax : ax - bx;
                            n_dy = -((by > ay) ? by - ay : ay - by);
                            n_sx = (ax < bx) ? CW'(1) : -CW'(1);
                            n_sy = (ay < by) ? CW'(1) : -CW'(1);
                            n_err = (CW+1)'(n_dx) + (CW+1)'(n_dy);
                            n_state = ST_LINE;
                        end
                        CMD_FILL: begin
                            n_x0 = (ax < 0) ? '0 : ax;
                            n_y  = (ay < 0) ? '0 : ay;
                            n_x  = n_x0;
                            n_x1 = (rx1 > w_eff) ? w_eff : rx1;
                            n_y1 = (ry1 > h_eff) ? h_eff : ry1;
                            if (i_rect_width > 0 && i_rect_height > 0 &&
                                n_x0 < n_x1 && n_y < n_y1)
                                n_state = ST_RECT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RECT: begin
                we = 1'b1;
                if (r_x + 1 >= r_x1) begin
                    n_x = r_x0;
                    n_y = r_y + 1;
                    if (r_y + 1 >= r_y1) n_state = ST_IDLE;
                end else begin
                    n_x = r_x + 1;
                end
            end
            ST_LINE: begin
                we = in_frame;
                if (r_x == r_x1 && r_y == r_y1) begin
                    n_state = ST_IDLE;
                end else begin
                    n_err = r_err;
                    if (e2 >= (CW+1)'(r_dy)) begin
                        n_err = n_err + (CW+1)'(r_dy);
                        n_x = r_x + r_sx;
                    end
                    if (e2 <= (CW+1)'(r_dx)) begin
                        n_err = n_err + (CW+1)'(r_dx);
                        n_y = r_y + r_sy;
                    end
                end
            end
            ST_RWAIT: n_state = ST_RDATA;   // RAM read latency
            ST_RDATA: begin
                n_pix = (r_pix != 0) ? rdata : 8'd0;
                n_pv = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_x0 <= n_x0; r_x1 <= n_x1; r_y1 <= n_y1;
        r_dx <= n_dx; r_dy <= n_dy; r_sx <= n_sx; r_sy <= n_sy;
        r_err <= n_err; r_color <= n_color; r_pix <= n_pix;
    end

    assign o_pix_valid = r_pv;
    assign o_pixel_value = r_pix;
endmodule
